FILE: design/prs_pkg.sv
//------------------------------------------------------------------------------
// prs_pkg
// Shared types and codes for the priority ready queue scheduler: request
// opcodes, response status codes, sequencer states and inter-module structs.
//------------------------------------------------------------------------------
`default_nettype none

package prs_pkg;

   // Field widths fixed by the request and response formats
   localparam int PRIO_W      = 4;
   localparam int ID_W        = 31;
   localparam int PARENT_W    = 32;
   localparam int SLOT_PORT_W = 6;
   localparam int STATUS_W    = 3;

   // Task id counter runs 1 .. all ones, then wraps to 1
   localparam logic [ID_W-1:0] ID_FIRST = ID_W'(1);
   localparam logic [ID_W-1:0] ID_LAST  = {ID_W{1'b1}};

   // Request opcodes
   typedef enum logic [1:0] {
      OP_CREATE     = 2'd0,
      OP_MAKE_READY = 2'd1,
      OP_SCHEDULE   = 2'd2,
      OP_LOOKUP     = 2'd3
   } opcode_type;

   // Response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_PRIO = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_NONE     = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_BAD_SLOT = 3'd4;

   // Sequencer states, one-hot
   typedef enum logic [7:0] {
      S_IDLE    = 8'b0000_0001,
      S_DECODE  = 8'b0000_0010,
      S_SCAN    = 8'b0000_0100,
      S_FETCH   = 8'b0000_1000,
      S_ENQUEUE = 8'b0001_0000,
      S_POP     = 8'b0010_0000,
      S_READ    = 8'b0100_0000,
      S_REPORT  = 8'b1000_0000
   } state_type;

   // Search unit status back to the sequencer
   typedef struct packed {
      logic done;
      logic found;
   } scan_stat_type;

   // Slot store write enables
   typedef struct packed {
      logic slot_we;
      logic next_we;
   } store_ctl_type;

endpackage

`default_nettype wire

FILE: design/priority_ready_queue_scheduler.sv
//------------------------------------------------------------------------------
// priority_ready_queue_scheduler
// Task table with one FIFO ready queue per priority level. Requests create,
// make ready, schedule or look up tasks; each request gives one response.
//------------------------------------------------------------------------------
// A failed search responds once the last slot (schedule: last level) is compared.
// The shared search unit walks the slot table or level list one entry a cycle.
// One request at a time: busy is high from accept until the response strobe.
// Synchronous reset empties all slots and queues and sets the next id to 1.
`default_nettype none

module priority_ready_queue_scheduler import prs_pkg::*; #(
   parameter int NUM_SLOTS  = 64,
   parameter int NUM_LEVELS = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output      logic                   busy,
   input  wire logic [1:0]             req_opcode,
   input  wire logic [PRIO_W-1:0]      req_priority_req,
   input  wire logic signed [PARENT_W-1:0] req_parent_id,
   input  wire logic [SLOT_PORT_W-1:0] req_slot,
   input  wire logic [ID_W-1:0]        req_task_id,
   output      logic                   rsp_valid,
   output      logic [STATUS_W-1:0]    rsp_status,
   output      logic [SLOT_PORT_W-1:0] rsp_out_slot,
   output      logic [ID_W-1:0]        rsp_out_id,
   output      logic [PRIO_W-1:0]      rsp_out_priority,
   output      logic signed [PARENT_W-1:0] rsp_out_parent
);

   localparam int SLOT_W = $clog2(NUM_SLOTS);
   localparam int LVL_W  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
   localparam int SCAN_W = (SLOT_W > LVL_W) ? SLOT_W : LVL_W;

   // Sequencer and latched request
   state_type            state_ff, state_in;
   opcode_type           op_ff, op_in;
   logic [PRIO_W-1:0]    prio_ff, prio_in;
   logic [PARENT_W-1:0]  parent_ff, parent_in;
   logic [SLOT_PORT_W-1:0] slot_ff, slot_in;
   logic [ID_W-1:0]      tid_ff, tid_in;
   logic [SLOT_W-1:0]    res_slot_ff, res_slot_in;
   logic [LVL_W-1:0]     lvl_ff, lvl_in;
   logic [ID_W-1:0]      id_counter_ff, id_counter_in;

   // Slot state bits and ready queues
   logic [NUM_SLOTS-1:0]  used_ff, used_in;
   logic [NUM_SLOTS-1:0]  ready_ff, ready_in;
   logic [NUM_LEVELS-1:0] nonempty_ff, nonempty_in;
   logic [SLOT_W-1:0]     head_ff [NUM_LEVELS];
   logic [SLOT_W-1:0]     tail_ff [NUM_LEVELS];
   logic                  head_we, tail_we;
   logic [SLOT_W-1:0]     head_wdata;
   logic [LVL_W-1:0]      q_lvl;
   logic [LVL_W-1:0]      enq_lvl;

   // Response registers
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [SLOT_PORT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [ID_W-1:0]        rsp_id_ff, rsp_id_in;
   logic [PRIO_W-1:0]      rsp_prio_ff, rsp_prio_in;
   logic [PARENT_W-1:0]    rsp_parent_ff, rsp_parent_in;

   // Error exit
   logic                err_en;
   logic [STATUS_W-1:0] err_code;

   // Search unit
   logic                scan_start;
   logic [SCAN_W-1:0]   scan_last;
   logic                scan_hit;
   logic [SCAN_W-1:0]   scan_addr;
   logic [SCAN_W-1:0]   scan_idx;
   scan_stat_type       scan_stat;
   logic [SLOT_W-1:0]   cmp_slot;
   logic [LVL_W-1:0]    cmp_lvl;

   // Slot store
   store_ctl_type       store_ctl;
   logic [SLOT_W-1:0]   rd_addr;
   logic [ID_W-1:0]     rd_id;
   logic [PARENT_W-1:0] rd_parent;
   logic [PRIO_W-1:0]   rd_prio;
   logic [SLOT_W-1:0]   rd_next;

   prs_scan #(
      .IDX_W (SCAN_W)
   ) u_scan (
      .clock   (clock),
      .reset   (reset),
      .start   (scan_start),
      .last    (scan_last),
      .hit     (scan_hit),
      .addr    (scan_addr),
      .cmp_idx (scan_idx),
      .stat    (scan_stat)
   );

   prs_store #(
      .NUM_SLOTS (NUM_SLOTS),
      .SLOT_W    (SLOT_W)
   ) u_store (
      .clock     (clock),
      .ctl       (store_ctl),
      .wr_addr   (res_slot_ff),
      .wr_id     (id_counter_ff),
      .wr_parent (parent_ff),
      .wr_prio   (prio_ff),
      .next_addr (tail_ff[enq_lvl]),
      .next_data (res_slot_ff),
      .rd_addr   (rd_addr),
      .rd_id     (rd_id),
      .rd_parent (rd_parent),
      .rd_prio   (rd_prio),
      .rd_next   (rd_next)
   );

   // Search setup and hit test per opcode
   assign cmp_slot  = scan_idx[SLOT_W-1:0];
   assign cmp_lvl   = scan_idx[LVL_W-1:0];
   assign scan_last = (op_ff == OP_SCHEDULE) ? SCAN_W'(NUM_LEVELS - 1)
                                             : SCAN_W'(NUM_SLOTS - 1);

   always_comb begin
      case (op_ff)
         OP_CREATE:   scan_hit = !used_ff[cmp_slot];
         OP_LOOKUP:   scan_hit = used_ff[cmp_slot] && (rd_id == tid_ff);
         OP_SCHEDULE: scan_hit = nonempty_ff[cmp_lvl];
         default:     scan_hit = 1'b0;
      endcase
   end

   // Store read address: search address while scanning, else the result slot
   assign rd_addr = (state_ff == S_SCAN) ? scan_addr[SLOT_W-1:0] : res_slot_ff;

   // Level for enqueue: requested priority on create, stored one on make ready
   assign enq_lvl = (op_ff == OP_CREATE) ? prio_ff[LVL_W-1:0] : rd_prio[LVL_W-1:0];

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      prio_in       = prio_ff;
      parent_in     = parent_ff;
      slot_in       = slot_ff;
      tid_in        = tid_ff;
      res_slot_in   = res_slot_ff;
      lvl_in        = lvl_ff;
      id_counter_in = id_counter_ff;
      used_in       = used_ff;
      ready_in      = ready_ff;
      nonempty_in   = nonempty_ff;
      head_we       = 1'b0;
      tail_we       = 1'b0;
      head_wdata    = res_slot_ff;
      q_lvl         = lvl_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_prio_in   = rsp_prio_ff;
      rsp_parent_in = rsp_parent_ff;
      err_en        = 1'b0;
      err_code      = STATUS_OK;
      scan_start    = 1'b0;
      store_ctl     = '0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in     = opcode_type'(req_opcode);
               prio_in   = req_priority_req;
               parent_in = req_parent_id;
               slot_in   = req_slot;
               tid_in    = req_task_id;
               state_in  = S_DECODE;
            end
         end

         S_DECODE: begin
            case (op_ff)
               OP_CREATE: begin
                  if ({1'b0, prio_ff} >= (PRIO_W + 1)'(NUM_LEVELS)) begin
                     err_en   = 1'b1;
                     err_code = STATUS_BAD_PRIO;
                  end else begin
                     scan_start = 1'b1;
                     state_in   = S_SCAN;
                  end
               end
               OP_MAKE_READY: begin
                  // only an active slot (used, not queued) may be re-queued
                  if (({1'b0, slot_ff} >= (SLOT_PORT_W + 1)'(NUM_SLOTS))
                      || !used_ff[slot_ff[SLOT_W-1:0]]
                      || ready_ff[slot_ff[SLOT_W-1:0]]) begin
                     err_en   = 1'b1;
                     err_code = STATUS_BAD_SLOT;
                  end else begin
                     res_slot_in = slot_ff[SLOT_W-1:0];
                     state_in    = S_FETCH;
                  end
               end
               default: begin
                  scan_start = 1'b1;
                  state_in   = S_SCAN;
               end
            endcase
         end

         S_SCAN: begin
            if (scan_stat.done) begin
               if (!scan_stat.found) begin
                  err_en   = 1'b1;
                  err_code = (op_ff == OP_CREATE) ? STATUS_FULL : STATUS_NONE;
               end else begin
                  case (op_ff)
                     OP_CREATE: begin
                        res_slot_in = cmp_slot;
                        state_in    = S_ENQUEUE;
                     end
                     OP_SCHEDULE: begin
                        lvl_in      = cmp_lvl;
                        res_slot_in = head_ff[cmp_lvl];
                        state_in    = S_FETCH;
                     end
                     default: begin
                        res_slot_in = cmp_slot;
                        state_in    = S_READ;
                     end
                  endcase
               end
            end
         end

         // read data for the result slot arrives next cycle
         S_FETCH: begin
            state_in = (op_ff == OP_SCHEDULE) ? S_POP : S_ENQUEUE;
         end

         // append result slot at the tail of its level
         S_ENQUEUE: begin
            if (op_ff == OP_CREATE) begin
               store_ctl.slot_we = 1'b1;
               id_counter_in = (id_counter_ff == ID_LAST) ? ID_FIRST
                                                          : id_counter_ff + ID_W'(1);
            end
            used_in[res_slot_ff]  = 1'b1;
            ready_in[res_slot_ff] = 1'b1;
            q_lvl = enq_lvl;
            if (nonempty_ff[enq_lvl]) begin
               store_ctl.next_we = 1'b1;
            end else begin
               head_we              = 1'b1;
               head_wdata           = res_slot_ff;
               nonempty_in[enq_lvl] = 1'b1;
            end
            tail_we  = 1'b1;
            state_in = S_READ;
         end

         // remove the head of the chosen level and mark it active
         S_POP: begin
            ready_in[res_slot_ff] = 1'b0;
            q_lvl = lvl_ff;
            if (res_slot_ff == tail_ff[lvl_ff]) begin
               nonempty_in[lvl_ff] = 1'b0;
            end else begin
               head_we    = 1'b1;
               head_wdata = rd_next;
            end
            state_in = S_READ;
         end

         S_READ: begin
            state_in = S_REPORT;
         end

         S_REPORT: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = STATUS_OK;
            rsp_slot_in   = SLOT_PORT_W'(res_slot_ff);
            rsp_id_in     = rd_id;
            rsp_prio_in   = rd_prio;
            rsp_parent_in = rd_parent;
            state_in      = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // failed request: status only, fields zero
      if (err_en) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = err_code;
         rsp_slot_in   = '0;
         rsp_id_in     = '0;
         rsp_prio_in   = '0;
         rsp_parent_in = '0;
         state_in      = S_IDLE;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         id_counter_ff <= ID_FIRST;
         used_ff       <= '0;
         ready_ff      <= '0;
         nonempty_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         id_counter_ff <= id_counter_in;
         used_ff       <= used_in;
         ready_ff      <= ready_in;
         nonempty_ff   <= nonempty_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      prio_ff       <= prio_in;
      parent_ff     <= parent_in;
      slot_ff       <= slot_in;
      tid_ff        <= tid_in;
      res_slot_ff   <= res_slot_in;
      lvl_ff        <= lvl_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_prio_ff   <= rsp_prio_in;
      rsp_parent_ff <= rsp_parent_in;
      if (head_we) begin
         head_ff[q_lvl] <= head_wdata;
      end
      if (tail_we) begin
         tail_ff[q_lvl] <= res_slot_ff;
      end
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_slot     = rsp_slot_ff;
   assign rsp_out_id       = rsp_id_ff;
   assign rsp_out_priority = rsp_prio_ff;
   assign rsp_out_parent   = rsp_parent_ff;

   // A response always comes out as the sequencer returns to idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response strobe while busy");

   // A queued slot is always an allocated slot
   a_ready_used: assert property (@(posedge clock) disable iff (reset)
      (ready_ff & ~used_ff) == '0)
      else $error("ready bit set on an unused slot");

   // Search finishes only while the sequencer waits for it
   a_scan_state: assert property (@(posedge clock) disable iff (reset)
      scan_stat.done |-> (state_ff == S_SCAN))
      else $error("search done outside scan state");

   // Pop only from a level that holds tasks
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POP) |-> nonempty_ff[lvl_ff])
      else $error("pop from an empty level");

   // Failed requests carry zero fields
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STATUS_OK)) |->
         ((rsp_out_id == '0) && (rsp_out_slot == '0)))
      else $error("nonzero fields on failed request");

endmodule

`default_nettype wire

FILE: design/prs_scan.sv
//------------------------------------------------------------------------------
// prs_scan
// Shared search unit: steps an index from zero to a given last entry, one
// entry per cycle, and stops at the first entry for which hit is raised.
// hit refers to cmp_idx, which is addr registered, to match a
// registered memory read issued at addr.
//------------------------------------------------------------------------------
`default_nettype none

module prs_scan import prs_pkg::*; #(
   parameter int IDX_W = 6
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [IDX_W-1:0] last,
   input  wire logic             hit,
   output      logic [IDX_W-1:0] addr,
   output      logic [IDX_W-1:0] cmp_idx,
   output      scan_stat_type    stat
);

   logic             active_ff, active_in;
   logic             cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0] addr_ff, addr_in;
   logic [IDX_W-1:0] cmp_ff, cmp_in;

   // Stop on a hit or after the last entry has been compared
   always_comb begin
      stat.found = hit;
      stat.done  = active_ff && cmp_vld_ff && (hit || (cmp_ff == last));
   end

   // Index stepping
   always_comb begin
      active_in  = active_ff;
      cmp_vld_in = cmp_vld_ff;
      addr_in    = addr_ff;
      cmp_in     = cmp_ff;
      if (start) begin
         active_in  = 1'b1;
         cmp_vld_in = 1'b0;
         addr_in    = '0;
      end else if (active_ff) begin
         if (stat.done) begin
            active_in  = 1'b0;
            cmp_vld_in = 1'b0;
         end else begin
            cmp_in     = addr_ff;
            cmp_vld_in = 1'b1;
            addr_in    = (addr_ff == last) ? addr_ff : addr_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         cmp_vld_ff <= 1'b0;
      end else begin
         active_ff  <= active_in;
         cmp_vld_ff <= cmp_vld_in;
      end
      addr_ff <= addr_in;
      cmp_ff  <= cmp_in;
   end

   assign addr    = addr_ff;
   assign cmp_idx = cmp_ff;

endmodule

`default_nettype wire

FILE: design/prs_store.sv
//------------------------------------------------------------------------------
// prs_store
// Slot table memories: task id, parent id, priority and ready-list link.
// One write address for the task fields, one for the link, one shared
// registered read address.
//------------------------------------------------------------------------------
`default_nettype none

module prs_store import prs_pkg::*; #(
   parameter int NUM_SLOTS = 64,
   parameter int SLOT_W    = 6
) (
   input  wire logic                clock,
   input  wire store_ctl_type       ctl,
   input  wire logic [SLOT_W-1:0]   wr_addr,
   input  wire logic [ID_W-1:0]     wr_id,
   input  wire logic [PARENT_W-1:0] wr_parent,
   input  wire logic [PRIO_W-1:0]   wr_prio,
   input  wire logic [SLOT_W-1:0]   next_addr,
   input  wire logic [SLOT_W-1:0]   next_data,
   input  wire logic [SLOT_W-1:0]   rd_addr,
   output      logic [ID_W-1:0]     rd_id,
   output      logic [PARENT_W-1:0] rd_parent,
   output      logic [PRIO_W-1:0]   rd_prio,
   output      logic [SLOT_W-1:0]   rd_next
);

   logic [ID_W-1:0]     id_mem     [NUM_SLOTS];
   logic [PARENT_W-1:0] parent_mem [NUM_SLOTS];
   logic [PRIO_W-1:0]   prio_mem   [NUM_SLOTS];
   logic [SLOT_W-1:0]   next_mem   [NUM_SLOTS];

   logic [ID_W-1:0]     rd_id_ff;
   logic [PARENT_W-1:0] rd_parent_ff;
   logic [PRIO_W-1:0]   rd_prio_ff;
   logic [SLOT_W-1:0]   rd_next_ff;

   // Writes
   always_ff @(posedge clock) begin
      if (ctl.slot_we) begin
         id_mem[wr_addr]     <= wr_id;
         parent_mem[wr_addr] <= wr_parent;
         prio_mem[wr_addr]   <= wr_prio;
      end
      if (ctl.next_we) begin
         next_mem[next_addr] <= next_data;
      end
   end

   // Registered reads
   always_ff @(posedge clock) begin
      rd_id_ff     <= id_mem[rd_addr];
      rd_parent_ff <= parent_mem[rd_addr];
      rd_prio_ff   <= prio_mem[rd_addr];
      rd_next_ff   <= next_mem[rd_addr];
   end

   assign rd_id     = rd_id_ff;
   assign rd_parent = rd_parent_ff;
   assign rd_prio   = rd_prio_ff;
   assign rd_next   = rd_next_ff;

endmodule

`default_nettype wire
